// ----- design/gtz_pkg.sv -----
`timescale 1ns / 1ps

package gtz_pkg;

  // Field and register widths.
  localparam int SMP_W      = 16;
  localparam int COEF_W     = 19;
  localparam int TRIG_W     = 18;
  localparam int WLEN_W     = 11;
  localparam int MAG_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  // Datapath widths.
  localparam int DLY_W  = 40;   // delay registers, 8 fractional bits
  localparam int HALF_W = 20;   // delay registers enter the multiplier in two halves
  localparam int MOP_W  = 26;   // multiplier operand
  localparam int PROD_W = 52;   // multiplier product
  localparam int ACC_W  = 62;   // accumulator
  localparam int SUM_W  = 48;   // recurrence sum before saturation
  localparam int COMP_W = 25;   // scaled real or imaginary part, up to 2^24
  localparam int DIVD_W = 43;   // dividend of the scaling division
  localparam int RAD_W  = 50;   // radicand of the root
  localparam int REM_W  = 28;   // partial remainder of the serial unit

  localparam int SERU_STEPS = 25;
  localparam int STEP_W     = 5;

  localparam logic [DLY_W-1:0]  DLY_MAX    = 40'h7F_FFFF_FFFF;
  localparam logic [DLY_W-1:0]  DLY_MIN    = 40'h80_0000_0000;
  localparam logic [ACC_W-1:0]  ROUND_HALF = 62'd32768;
  localparam logic [COMP_W-1:0] COMP_CLAMP = 25'h100_0000;
  localparam logic [MAG_W-1:0]  MAG_MAX    = 24'hFF_FFFF;

  // Register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_WLEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN  = 2'd3;

  localparam logic [WLEN_W-1:0] WLEN_RST = 11'd205;
  localparam logic [COEF_W-1:0] COEF_RST = '0;
  localparam logic [TRIG_W-1:0] COS_RST  = 18'h1_0000;
  localparam logic [TRIG_W-1:0] SIN_RST  = '0;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RHI,
    ST_RADD,
    ST_RUPD,
    ST_CLO,
    ST_CHI,
    ST_CADD,
    ST_DIVA,
    ST_SHI,
    ST_SADD,
    ST_WAITA,
    ST_WAITB,
    ST_SQA,
    ST_SQB,
    ST_SQADD,
    ST_ROOT,
    ST_WAITR
  } gtz_state_e;

  typedef enum logic [3:0] {
    MAC_HOLD,
    MAC_START,
    MAC_RHI,
    MAC_RADD,
    MAC_RUPD,
    MAC_CLO,
    MAC_CHI,
    MAC_CADD,
    MAC_SLO,
    MAC_SHI,
    MAC_SADD,
    MAC_SQA,
    MAC_SQB,
    MAC_SQADD,
    MAC_CLEAR
  } mac_op_e;

  typedef enum logic {
    SERU_DIV,
    SERU_ROOT
  } seru_mode_e;

  typedef struct packed {
    logic       start;
    seru_mode_e mode;
  } seru_cmd_t;

endpackage

// ----- design/goertzel_tone_magnitude_core.sv -----
`timescale 1ns / 1ps

// Single-bin Goertzel detector. Each signed 16-bit sample runs the recurrence
// q0 = coeff*q1 - q2 + x through one 26x26 multiplier, fed with the 40-bit
// delay registers in two 20-bit halves; each sample takes two partial
// products, their sum, and the saturating update of the delay pair.
// After window_length samples the block forms real = q1 - q2*cos and
// imag = q2*sin on the same multiplier, scales each by 2/N in a 25-step
// serial divider, squares and adds them, and takes a 25-step serial root
// rounded to nearest. No sample item is taken while a window closes. The
// magnitude item sits in an output register, so the next window starts
// while it waits. Writes to the configuration registers never clear the
// running window.
module goertzel_tone_magnitude_core import gtz_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SMP_W-1:0]      sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MAG_W-1:0]      magnitude_o
);

  localparam int NW = $clog2(MAX_WINDOW + 1);

  logic [WLEN_W-1:0] wlen_q;
  logic [COEF_W-1:0] coef_q;
  logic [TRIG_W-1:0] cos_q, sin_q;

  gtz_state_e        state_q, state_d;
  logic [NW-1:0]     cnt_q, cnt_inc, n_eff;
  logic              last;
  logic [COMP_W-1:0] a_q, b_q;
  logic              out_valid_q;
  logic [MAG_W-1:0]  mag_q;
  logic              slot_free;

  mac_op_e           mac_op;
  seru_cmd_t         seru_cmd;
  logic              seru_busy;
  logic [COMP_W-1:0] seru_res;
  logic              cap_a, cap_b, fin, cnt_step;

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_abs;
  logic [63:0]       num;
  logic [DIVD_W-1:0] dividend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RST;
      coef_q <= COEF_RST;
      cos_q  <= COS_RST;
      sin_q  <= SIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WLEN: wlen_q <= cfg_data_i[WLEN_W-1:0];
        CFG_COEF: coef_q <= cfg_data_i[COEF_W-1:0];
        CFG_COS:  cos_q  <= cfg_data_i[TRIG_W-1:0];
        CFG_SIN:  sin_q  <= cfg_data_i[TRIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A zero length acts as one and an oversized one as the maximum.
  always_comb begin
    if (wlen_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(wlen_q) > MAX_WINDOW) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(wlen_q);
    end
  end

  assign cnt_inc   = cnt_q + NW'(1);
  assign last      = cnt_inc >= n_eff;
  assign slot_free = !out_valid_q || out_ready_i;

  // Scaling numerator: 2*|v| + N*2^15; the low 16 bits drop out of the quotient.
  assign acc_abs  = acc[ACC_W-1] ? (~acc + ACC_W'(1)) : acc;
  assign num      = {1'b0, acc_abs, 1'b0} + (64'(n_eff) << 15);
  assign dividend = num[DIVD_W+15:16];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_RHI;
      ST_RHI:   state_d = ST_RADD;
      ST_RADD:  state_d = ST_RUPD;
      ST_RUPD:  state_d = last ? ST_CLO : ST_IDLE;
      ST_CLO:   state_d = ST_CHI;
      ST_CHI:   state_d = ST_CADD;
      ST_CADD:  state_d = ST_DIVA;
      ST_DIVA:  state_d = ST_SHI;
      ST_SHI:   state_d = ST_SADD;
      ST_SADD:  state_d = ST_WAITA;
      ST_WAITA: if (!seru_busy) state_d = ST_WAITB;
      ST_WAITB: if (!seru_busy) state_d = ST_SQA;
      ST_SQA:   state_d = ST_SQB;
      ST_SQB:   state_d = ST_SQADD;
      ST_SQADD: state_d = ST_ROOT;
      ST_ROOT:  state_d = ST_WAITR;
      ST_WAITR: if (!seru_busy && slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    mac_op        = MAC_HOLD;
    seru_cmd      = '{start: 1'b0, mode: SERU_DIV};
    cap_a         = 1'b0;
    cap_b         = 1'b0;
    fin           = 1'b0;
    cnt_step      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) mac_op = MAC_START;
      end
      ST_RHI:  mac_op = MAC_RHI;
      ST_RADD: mac_op = MAC_RADD;
      ST_RUPD: begin
        mac_op   = MAC_RUPD;
        cnt_step = 1'b1;
      end
      ST_CLO:  mac_op = MAC_CLO;
      ST_CHI:  mac_op = MAC_CHI;
      ST_CADD: mac_op = MAC_CADD;
      ST_DIVA: begin
        // The accumulator holds the real part here.
        mac_op   = MAC_SLO;
        seru_cmd = '{start: 1'b1, mode: SERU_DIV};
      end
      ST_SHI:  mac_op = MAC_SHI;
      ST_SADD: mac_op = MAC_SADD;
      ST_WAITA: begin
        if (!seru_busy) begin
          cap_a    = 1'b1;
          seru_cmd = '{start: 1'b1, mode: SERU_DIV};
        end
      end
      ST_WAITB: cap_b = !seru_busy;
      ST_SQA:   mac_op = MAC_SQA;
      ST_SQB:   mac_op = MAC_SQB;
      ST_SQADD: mac_op = MAC_SQADD;
      ST_ROOT:  seru_cmd = '{start: 1'b1, mode: SERU_ROOT};
      ST_WAITR: begin
        if (!seru_busy && slot_free) begin
          fin    = 1'b1;
          mac_op = MAC_CLEAR;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cnt_step) begin
        cnt_q <= last ? '0 : cnt_inc;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_a) a_q <= seru_res;
    if (cap_b) b_q <= seru_res;
    if (fin)   mag_q <= seru_res[MAG_W-1:0];
  end

  gtz_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (mac_op),
    .sample_i (sample_i),
    .coeff_i  (coef_q),
    .cos_i    (cos_q),
    .sin_i    (sin_q),
    .comp_a_i (a_q),
    .comp_b_i (b_q),
    .acc_o    (acc)
  );

  gtz_seru #(
    .DVW (NW)
  ) u_seru (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (seru_cmd),
    .dividend_i (dividend),
    .divisor_i  (n_eff),
    .radicand_i (acc[RAD_W-1:0]),
    .busy_o     (seru_busy),
    .result_o   (seru_res)
  );

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;

endmodule

// ----- design/gtz_mac.sv -----
`timescale 1ns / 1ps

module gtz_mac import gtz_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_op_e                  op_i,
  input  logic [SMP_W-1:0]         sample_i,
  input  logic [COEF_W-1:0]        coeff_i,
  input  logic [TRIG_W-1:0]        cos_i,
  input  logic [TRIG_W-1:0]        sin_i,
  input  logic [COMP_W-1:0]        comp_a_i,
  input  logic [COMP_W-1:0]        comp_b_i,
  output logic [ACC_W-1:0]         acc_o
);

  logic [DLY_W-1:0]  q1_q, q2_q;
  logic [SMP_W-1:0]  x_q;
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc_q, acc_d;

  logic signed [MOP_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic [MOP_W-1:0] coef_x, cos_x, sin_x, q1_lo, q1_hi, q2_lo, q2_hi, ca_x, cb_x;
  logic [ACC_W-1:0] prod_sx, prod_sh, q1_sh;
  logic [SUM_W-1:0] t_sum, q2_sum, x_sum, rec_sum;
  logic [DLY_W-1:0] q0;

  assign coef_x = {{(MOP_W-COEF_W){coeff_i[COEF_W-1]}}, coeff_i};
  assign cos_x  = {{(MOP_W-TRIG_W){cos_i[TRIG_W-1]}}, cos_i};
  assign sin_x  = {{(MOP_W-TRIG_W){sin_i[TRIG_W-1]}}, sin_i};
  // The low half is unsigned and the high half carries the sign.
  assign q1_lo  = {{(MOP_W-HALF_W){1'b0}}, q1_q[HALF_W-1:0]};
  assign q1_hi  = {{(MOP_W-HALF_W){q1_q[DLY_W-1]}}, q1_q[DLY_W-1:HALF_W]};
  assign q2_lo  = {{(MOP_W-HALF_W){1'b0}}, q2_q[HALF_W-1:0]};
  assign q2_hi  = {{(MOP_W-HALF_W){q2_q[DLY_W-1]}}, q2_q[DLY_W-1:HALF_W]};
  assign ca_x   = {1'b0, comp_a_i};
  assign cb_x   = {1'b0, comp_b_i};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      MAC_START: begin mul_a = coef_x; mul_b = q1_lo; end
      MAC_RHI:   begin mul_a = coef_x; mul_b = q1_hi; end
      MAC_CLO:   begin mul_a = cos_x;  mul_b = q2_lo; end
      MAC_CHI:   begin mul_a = cos_x;  mul_b = q2_hi; end
      MAC_SLO:   begin mul_a = sin_x;  mul_b = q2_lo; end
      MAC_SHI:   begin mul_a = sin_x;  mul_b = q2_hi; end
      MAC_SQA:   begin mul_a = ca_x;   mul_b = ca_x;  end
      MAC_SQB:   begin mul_a = cb_x;   mul_b = cb_x;  end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign prod_sx = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign prod_sh = {prod_q[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}};
  assign q1_sh   = {{(ACC_W-DLY_W-16){q1_q[DLY_W-1]}}, q1_q, 16'b0};

  // The accumulator holds coeff*q1 plus one half; dropping 16 bits floors it.
  assign t_sum   = {{(SUM_W-ACC_W+16){acc_q[ACC_W-1]}}, acc_q[ACC_W-1:16]};
  assign q2_sum  = {{(SUM_W-DLY_W){q2_q[DLY_W-1]}}, q2_q};
  assign x_sum   = {{(SUM_W-SMP_W-8){x_q[SMP_W-1]}}, x_q, 8'b0};
  assign rec_sum = t_sum - q2_sum + x_sum;

  always_comb begin
    if (rec_sum[SUM_W-1:DLY_W-1] == {(SUM_W-DLY_W+1){rec_sum[SUM_W-1]}}) begin
      q0 = rec_sum[DLY_W-1:0];
    end else if (rec_sum[SUM_W-1]) begin
      q0 = DLY_MIN;
    end else begin
      q0 = DLY_MAX;
    end
  end

  always_comb begin
    acc_d = acc_q;
    case (op_i)
      MAC_RHI:   acc_d = prod_sx + ROUND_HALF;
      MAC_RADD:  acc_d = acc_q + prod_sh;
      MAC_CLO:   acc_d = q1_sh;
      MAC_CHI:   acc_d = acc_q - prod_sx;
      MAC_CADD:  acc_d = acc_q - prod_sh;
      MAC_SHI:   acc_d = prod_sx;
      MAC_SADD:  acc_d = acc_q + prod_sh;
      MAC_SQB:   acc_d = prod_sx;
      MAC_SQADD: acc_d = acc_q + prod_sx;
      default:   acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    acc_q  <= acc_d;
    if (op_i == MAC_START) begin
      x_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_q <= '0;
      q2_q <= '0;
    end else if (op_i == MAC_RUPD) begin
      q2_q <= q1_q;
      q1_q <= q0;
    end else if (op_i == MAC_CLEAR) begin
      q1_q <= '0;
      q2_q <= '0;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- design/gtz_seru.sv -----
`timescale 1ns / 1ps

module gtz_seru import gtz_pkg::*; #(
  parameter int DVW = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  seru_cmd_t         cmd_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DVW-1:0]    divisor_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              busy_o,
  output logic [COMP_W-1:0] result_o
);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  seru_mode_e        mode_q;
  logic [RAD_W-1:0]  src_q;
  logic [REM_W-1:0]  rem_q;
  logic [COMP_W-1:0] res_q;
  logic [DVW-1:0]    dvs_q;
  logic              ovf_q;

  logic [REM_W-1:0]  rem_sh, trial, diff;
  logic              ge;
  logic [RAD_W-1:0]  src_nx;
  logic              ovf_in;
  logic [COMP_W:0]   rnd;

  // A quotient of 2^25 or more is clamped anyway, so the loop starts from a zero remainder and its result is ignored.
  assign ovf_in = 32'(dividend_i[DIVD_W-1:COMP_W]) >= 32'(divisor_i);

  always_comb begin
    if (mode_q == SERU_DIV) begin
      rem_sh = {rem_q[REM_W-2:0], src_q[RAD_W-1]};
      trial  = REM_W'(dvs_q);
      src_nx = {src_q[RAD_W-2:0], 1'b0};
    end else begin
      rem_sh = {rem_q[REM_W-3:0], src_q[RAD_W-1:RAD_W-2]};
      trial  = {1'b0, res_q, 2'b01};
      src_nx = {src_q[RAD_W-3:0], 2'b00};
    end
    ge   = rem_sh >= trial;
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      mode_q <= SERU_DIV;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      step_q <= '0;
      mode_q <= cmd_i.mode;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(SERU_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      res_q <= '0;
      dvs_q <= divisor_i;
      if (cmd_i.mode == SERU_DIV) begin
        src_q <= {dividend_i[COMP_W-1:0], {(RAD_W-COMP_W){1'b0}}};
        rem_q <= ovf_in ? '0 : REM_W'(dividend_i[DIVD_W-1:COMP_W]);
        ovf_q <= ovf_in;
      end else begin
        src_q <= radicand_i;
        rem_q <= '0;
        ovf_q <= 1'b0;
      end
    end else if (busy_q) begin
      src_q <= src_nx;
      rem_q <= ge ? diff : rem_sh;
      res_q <= {res_q[COMP_W-2:0], ge};
    end
  end

  // After the root loop the remainder is v - r*r, so r*r + r < v means rem > r.
  assign rnd = {1'b0, res_q} + (COMP_W+1)'(rem_q > REM_W'(res_q));

  always_comb begin
    if (mode_q == SERU_DIV) begin
      result_o = (ovf_q || (res_q > COMP_CLAMP)) ? COMP_CLAMP : res_q;
    end else if (rnd > (COMP_W+1)'(MAG_MAX)) begin
      result_o = COMP_W'(MAG_MAX);
    end else begin
      result_o = rnd[COMP_W-1:0];
    end
  end

  assign busy_o = busy_q;

endmodule
